@@ hdl/backward_lz_byte_decompressor_unit_defines.svh @@
// Assertion macros shared by the decompressor modules.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef BACKWARD_LZ_BYTE_DECOMPRESSOR_UNIT_DEFINES_SVH
`define BACKWARD_LZ_BYTE_DECOMPRESSOR_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define BLZ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequence is checked in the cycle after its antecedent.
`define BLZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hdl/blzd_pkg.sv @@
// Shared types and constants of the backward LZ byte decompressor.
// Depends on nothing; imported by the front end, queue, back end, top level and bench.
package blzd_pkg;

	// Front-end decoder phases.
	localparam logic [2:0] PH_KEY   = 3'd0;
	localparam logic [2:0] PH_LEN0  = 3'd1;
	localparam logic [2:0] PH_LEN1  = 3'd2;
	localparam logic [2:0] PH_LEN2  = 3'd3;
	localparam logic [2:0] PH_TOKEN = 3'd4;
	localparam logic [2:0] PH_DIST  = 3'd5;
	localparam logic [2:0] PH_COUNT = 3'd6;

	// Command kinds passed from the front end to the back end.
	localparam logic [1:0] CMD_LEN  = 2'd0;
	localparam logic [1:0] CMD_BYTE = 2'd1;
	localparam logic [1:0] CMD_COPY = 2'd2;

	localparam int unsigned COPY_BIAS = 3;

	// One classified command.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  value;    // literal byte or copy distance
		logic [8:0]  count;    // copy length, bias already added
		logic [23:0] length;   // header length
	} blzd_cmd_t;

endpackage

@@ hdl/blzd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module blzd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/blzd_front.sv @@
// Front end: takes compressed bytes, tracks the token phase, emits commands.
// Depends on blzd_pkg.
module blzd_front
	import blzd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [7:0] in_byte,
	input  logic      final_byte,
	output logic      cmd_valid,
	input  logic      cmd_ready,
	output blzd_cmd_t cmd
);

	logic [2:0]  phase_q;
	logic [7:0]  key_q;
	logic [23:0] len_q;
	logic [7:0]  dist_q;
	logic [2:0]  phase_d;
	logic        accept;
	logic        emit;

	assign in_ready  = cmd_ready;
	assign accept    = in_valid && in_ready;
	assign cmd_valid = in_valid && emit;

	// Decode of the current byte against the phase.
	always_comb begin
		phase_d   = PH_TOKEN;
		emit      = 1'b0;
		cmd.kind  = CMD_BYTE;
		cmd.value = in_byte;
		cmd.count = 9'(in_byte) + 9'(COPY_BIAS);
		cmd.length = {in_byte, len_q[15:0]};
		case (phase_q)
			PH_KEY:  phase_d = PH_LEN0;
			PH_LEN0: phase_d = PH_LEN1;
			PH_LEN1: phase_d = PH_LEN2;
			PH_LEN2: begin
				emit     = 1'b1;
				cmd.kind = CMD_LEN;
			end
			PH_DIST: begin
				if (in_byte == 8'd0) begin
					emit      = 1'b1;
					cmd.value = key_q;
				end else begin
					phase_d = PH_COUNT;
				end
			end
			PH_COUNT: begin
				emit      = 1'b1;
				cmd.kind  = CMD_COPY;
				cmd.value = dist_q;
			end
			default: begin
				if (in_byte == key_q) begin
					phase_d = PH_DIST;
				end else begin
					emit = 1'b1;
				end
			end
		endcase
		if (final_byte) begin
			phase_d = PH_KEY;
		end
	end

	// Phase and token registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
			key_q   <= '0;
			len_q   <= '0;
			dist_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_KEY: begin
					key_q <= in_byte;
					len_q <= '0;
				end
				PH_LEN0: len_q[7:0]  <= in_byte;
				PH_LEN1: len_q[15:8] <= in_byte;
				PH_LEN2: len_q[23:16] <= in_byte;
				PH_DIST: dist_q <= in_byte;
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/blzd_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on blzd_pkg and the defines header.
`include "backward_lz_byte_decompressor_unit_defines.svh"
module blzd_queue
	import blzd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_ready,
	input  blzd_cmd_t wr_cmd,
	input  logic      wr_last,
	output logic      rd_valid,
	input  logic      rd_ready,
	output blzd_cmd_t rd_cmd,
	output logic      rd_last
);

	blzd_cmd_t   ent_q [2];
	logic [1:0]  last_q;
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_cmd   = ent_q[rp_q];
	assign rd_last  = last_q[rp_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wr_cmd;
		end
	end

	// Pointers, count and per-entry marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			cnt_q  <= '0;
			last_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
				last_q[wp_q] <= wr_last;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	`BLZ_ASSERT_IMP(a_no_overflow, clk, arst_n, cnt_q == 2'd2, !push)
	`BLZ_ASSERT_NEXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
	`BLZ_ASSERT_IMP(a_valid_cnt, clk, arst_n, rd_valid, cnt_q != 2'd0)

endmodule

@@ hdl/blzd_back.sv @@
// Back end: carries out commands, keeps the history RAM, packs output beats.
// Depends on blzd_pkg, blzd_ram and the defines header.
`include "backward_lz_byte_decompressor_unit_defines.svh"
module blzd_back
	import blzd_pkg::*;
#(
	parameter int OUT_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  blzd_cmd_t   cmd,
	output logic        m_valid,
	input  logic        m_ready,
	output logic        m_kind,
	output logic [63:0] m_data,
	output logic [3:0]  m_count,
	output logic [23:0] m_length,
	output logic        m_last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_COPY = 2'd2;

	logic [1:0]  st_q;
	logic [7:0]  hp_q;
	logic [255:0] vld_q;
	logic [7:0]  dist_q;
	logic [8:0]  left_q;
	logic [3:0]  fill_q;
	logic [63:0] acc_q;
	logic        ovalid_q;
	logic        okind_q, olast_q;
	logic [63:0] odata_q;
	logic [3:0]  ocount_q;
	logic [23:0] olen_q;

	logic        we;
	logic [7:0]  wdata, rdata, raddr, rbyte;
	logic        out_free;
	logic        rd_vld_s1;
	logic        byte_go;
	logic [7:0]  byte_val;
	logic        byte_end;
	logic [63:0] acc_new;
	logic [3:0]  fill_new;

	assign out_free = !ovalid_q || m_ready;
	assign m_valid  = ovalid_q;
	assign m_kind   = okind_q;
	assign m_data   = odata_q;
	assign m_count  = ocount_q;
	assign m_length = olen_q;
	assign m_last   = olast_q;

	// History RAM; an entry never written reads as zero via its valid bit.
	assign raddr = hp_q - dist_q;
	blzd_ram #(.WIDTH(8), .DEPTH(256)) u_hist (
		.clk(clk), .we(we), .waddr(hp_q), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);
	assign rbyte = rd_vld_s1 ? rdata : 8'd0;

	// Byte source: a literal from idle, or a history byte during a copy.
	always_comb begin
		cmd_ready = 1'b0;
		byte_go   = 1'b0;
		byte_val  = cmd.value;
		byte_end  = 1'b1;
		case (st_q)
			ST_IDLE: begin
				if (cmd_valid && out_free) begin
					if (cmd.kind == CMD_BYTE) begin
						cmd_ready = 1'b1;
						byte_go   = 1'b1;
					end else if (cmd.kind == CMD_LEN) begin
						cmd_ready = 1'b1;
					end
				end
				if (cmd_valid && cmd.kind == CMD_COPY) begin
					cmd_ready = 1'b1;
				end
			end
			ST_COPY: begin
				if (out_free) begin
					byte_go  = 1'b1;
					byte_val = rbyte;
					byte_end = (left_q == 9'd1);
				end
			end
			default: ;
		endcase
	end

	assign we    = byte_go;
	assign wdata = byte_val;

	// New packing state after one byte.
	always_comb begin
		acc_new  = acc_q;
		acc_new[fill_q[2:0]*8 +: 8] = byte_val;
		fill_new = fill_q + 4'd1;
	end

	// Control and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			hp_q      <= '0;
			vld_q     <= '0;
			dist_q    <= '0;
			left_q    <= '0;
			fill_q    <= '0;
			acc_q     <= '0;
			ovalid_q  <= 1'b0;
			okind_q   <= 1'b0;
			odata_q   <= '0;
			ocount_q  <= '0;
			olen_q    <= '0;
			olast_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= vld_q[raddr];
			if (m_ready) begin
				ovalid_q <= 1'b0;
			end
			if (st_q == ST_IDLE && cmd_valid && cmd_ready && cmd.kind == CMD_LEN) begin
				ovalid_q <= 1'b1;
				okind_q  <= 1'b1;
				odata_q  <= '0;
				ocount_q <= '0;
				olen_q   <= cmd.length;
				olast_q  <= 1'b1;
			end
			if (st_q == ST_IDLE && cmd_valid && cmd.kind == CMD_COPY) begin
				dist_q <= cmd.value;
				left_q <= cmd.count;
				st_q   <= ST_READ;
			end
			if (st_q == ST_READ) begin
				st_q <= ST_COPY;
			end
			if (byte_go) begin
				vld_q[hp_q] <= 1'b1;
				hp_q <= hp_q + 8'd1;
				if (st_q == ST_COPY) begin
					left_q <= left_q - 9'd1;
					if (byte_end) begin
						st_q <= ST_IDLE;
					end else begin
						st_q <= ST_READ;
					end
				end
				if (byte_end || fill_new == 4'(OUT_BYTES)) begin
					ovalid_q <= 1'b1;
					okind_q  <= 1'b0;
					odata_q  <= acc_new;
					ocount_q <= fill_new;
					olen_q   <= '0;
					olast_q  <= byte_end;
					acc_q    <= '0;
					fill_q   <= '0;
				end else begin
					acc_q  <= acc_new;
					fill_q <= fill_new;
				end
			end
		end
	end

	`BLZ_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q < 4'(OUT_BYTES))
	`BLZ_ASSERT_IMP(a_copy_len, clk, arst_n, st_q == ST_COPY, left_q != 9'd0)
	`BLZ_ASSERT_NEXT(a_ptr_step, clk, arst_n, byte_go, hp_q == $past(hp_q) + 8'd1)

endmodule

@@ hdl/backward_lz_byte_decompressor_unit.sv @@
// Top level of the backward LZ byte decompressor.
// Depends on blzd_pkg, blzd_front, blzd_queue, blzd_back, blzd_ram and the defines header.
//
// Usage: compressed bytes enter on the s_axis channel, last image byte first,
// with s_axis_tlast marking the image's first byte (decoder then expects a new
// escape key). Results leave on m_axis: tuser 1 is a length report carrying
// the 24-bit header length, tuser 0 is a data beat of up to OUT_BYTES bytes,
// first produced byte in the lowest bits. m_axis_tlast marks the last beat
// caused by one input byte.
// Timing: a literal passes through a queue entry and the output register;
// literals sustain one beat per cycle while the output is taken. A copy of up
// to 258 bytes steps through a read state and a copy state per byte, as the
// history RAM's registered read feeds the next byte of an overlapping copy.
// The front end keeps classifying into a two-entry queue while a copy runs.
// Reset clears the decoder phase, the history valid bits and all handshakes;
// unwritten history reads as zero. When m_axis_tready is low the output
// register holds its beat, the back end stops and the queue fills, then
// s_axis_tready drops.
`include "backward_lz_byte_decompressor_unit_defines.svh"
module backward_lz_byte_decompressor_unit
	import blzd_pkg::*;
#(
	parameter int OUT_BYTES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // in_byte
	input  logic         s_axis_tlast,   // final_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata,   // data_bytes, byte_count, total_length, pad
	output logic         m_axis_tuser,   // out_kind
	output logic         m_axis_tlast    // run_last
);

	blzd_cmd_t   f_cmd, q_cmd;
	logic        f_valid, f_ready, q_valid, q_ready, q_last;
	logic [63:0] data;
	logic [3:0]  cnt;
	logic [23:0] len;

	blzd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_byte(s_axis_tdata), .final_byte(s_axis_tlast),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	blzd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_cmd(f_cmd), .wr_last(1'b1),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_cmd(q_cmd), .rd_last(q_last)
	);

	blzd_back #(.OUT_BYTES(OUT_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_valid && q_last), .cmd_ready(q_ready), .cmd(q_cmd),
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
		.m_kind(m_axis_tuser), .m_data(data), .m_count(cnt),
		.m_length(len), .m_last(m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, len, cnt, data};

	`BLZ_ASSERT_IMP(a_len_empty, clk, arst_n, m_axis_tvalid && m_axis_tuser, cnt == 4'd0)
	`BLZ_ASSERT_IMP(a_data_cnt, clk, arst_n, m_axis_tvalid && !m_axis_tuser, cnt != 4'd0)
	`BLZ_ASSERT_IMP(a_len_last, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the backward LZ byte decompressor unit.
// Depends on blzd_pkg and backward_lz_byte_decompressor_unit; predicts every output beat.
module tb_top;
	import blzd_pkg::*;

	localparam int OUT_BYTES = 8;
	localparam int MAX_CYCLES = 2000000;
	localparam int DRAIN_CYCLES = 600;

	// One result beat as the decoder should emit it.
	typedef struct packed {
		logic        kind;
		logic [63:0] bytes;
		logic [3:0]  count;
		logic [23:0] length;
		logic        last;
	} beat_t;

	typedef struct packed {
		logic [7:0] value;
		logic       fin;
	} cbyte_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [95:0]  m_axis_tdata;
	logic         m_axis_tuser;
	logic         m_axis_tlast;

	backward_lz_byte_decompressor_unit #(.OUT_BYTES(OUT_BYTES)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// Predictor state.
	logic [2:0]  dec_phase;
	logic [7:0]  dec_key;
	logic [23:0] dec_len;
	logic [7:0]  dec_dist;
	logic [7:0]  hist [256];
	logic [7:0]  hist_ptr;

	cbyte_t pending_bytes[$];
	beat_t  expected_beats[$];
	int     mismatches;
	int     cycles;
	bit     stim_done;
	bit     hold_sender;
	bit     calm_in;
	bit     calm_out;
	bit     in_fire;

	// Append one produced byte to the beat being assembled.
	task automatic emit_byte(input logic [7:0] v, inout beat_t cur, inout int fill);
		if (fill == 0)
			cur = '0;
		cur.bytes[8*fill +: 8] = v;
		fill++;
		cur.count = 4'(fill);
		if (fill == OUT_BYTES) begin
			expected_beats.push_back(cur);
			fill = 0;
		end
		hist[hist_ptr] = v;
		hist_ptr++;
	endtask

	// Advance the decoder by one compressed byte and queue its beats.
	task automatic decode_byte(input cbyte_t cb);
		beat_t cur;
		int fill;
		int first;
		int n;
		first = expected_beats.size();
		fill = 0;
		cur = '0;
		case (dec_phase)
			PH_KEY: begin
				dec_key = cb.value;
				dec_len = '0;
				dec_phase = PH_LEN0;
			end
			PH_LEN0: begin
				dec_len = {16'd0, cb.value};
				dec_phase = PH_LEN1;
			end
			PH_LEN1: begin
				dec_len[15:8] = cb.value;
				dec_phase = PH_LEN2;
			end
			PH_LEN2: begin
				dec_len[23:16] = cb.value;
				cur = '0;
				cur.kind = 1'b1;
				cur.length = dec_len;
				expected_beats.push_back(cur);
				dec_phase = PH_TOKEN;
			end
			PH_DIST: begin
				if (cb.value == 8'd0) begin
					emit_byte(dec_key, cur, fill);
					dec_phase = PH_TOKEN;
				end else begin
					dec_dist = cb.value;
					dec_phase = PH_COUNT;
				end
			end
			PH_COUNT: begin
				n = int'(cb.value) + COPY_BIAS;
				for (int i = 0; i < n; i++)
					emit_byte(hist[8'(hist_ptr - dec_dist)], cur, fill);
				dec_phase = PH_TOKEN;
			end
			default: begin
				if (cb.value == dec_key)
					dec_phase = PH_DIST;
				else begin
					emit_byte(cb.value, cur, fill);
					dec_phase = PH_TOKEN;
				end
			end
		endcase
		if (fill != 0)
			expected_beats.push_back(cur);
		if (cb.fin)
			dec_phase = PH_KEY;
		if (expected_beats.size() > first)
			expected_beats[expected_beats.size() - 1].last = 1'b1;
	endtask

	// Queue one compressed byte for the sender.
	task automatic put(input logic [7:0] v, input bit fin = 0);
		pending_bytes.push_back('{value: v, fin: fin});
	endtask

	// Random image: a header, then well-formed tokens, ending on a flagged byte.
	task automatic put_image(input int tokens, input bit broken);
		logic [7:0] key;
		logic [7:0] lit;
		int kind;
		key = 8'($urandom);
		put(key);
		put(8'($urandom)); put(8'($urandom)); put(8'($urandom));
		for (int t = 0; t < tokens; t++) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				lit = 8'($urandom);
				if (lit == key)
					lit = ~key;
				put(lit);
			end else if (kind == 6) begin
				put(key); put(8'd0);
			end else begin
				put(key);
				put(8'($urandom_range(1, 255)));
				put(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20)));
			end
		end
		if (broken)
			put(key, 1);
		else
			put(8'($urandom) ^ key | 8'h01, 1);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stimulus and reset.
	initial begin
		arst_n = 1'b0;
		for (int i = 0; i < 256; i++)
			hist[i] = 8'd0;
		dec_phase = PH_KEY;
		dec_key = '0;
		dec_len = '0;
		dec_dist = '0;
		hist_ptr = '0;
		mismatches = 0;
		stim_done = 0;
		hold_sender = 0;
		calm_in = 0;
		calm_out = 0;

		// Directed: header extremes, literal, escaped key, copies reaching
		// zeroed history, longest copy with overlap, images cut short.
		put(8'hFF); put(8'hFF); put(8'hFF); put(8'hFF);
		put(8'h00); put(8'h7E);
		put(8'hFF); put(8'h00);
		put(8'hFF); put(8'hFF); put(8'h00);
		put(8'hFF); put(8'h01); put(8'hFF);
		put(8'hFF); put(8'h02, 1);
		put(8'h00); put(8'h00); put(8'h00); put(8'h00, 1);
		put(8'h5A); put(8'h10); put(8'h00); put(8'h00);
		put(8'h5A, 1);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Let the directed part drain completely before random images.
		wait (pending_bytes.size() == 0);
		hold_sender = 1;
		wait (expected_beats.size() == 0);
		hold_sender = 0;

		for (int img = 0; img < 12; img++) begin
			if (img == 6) begin
				calm_in = 1;
				calm_out = 1;
			end else if (img == 8) begin
				calm_in = 0;
				calm_out = 0;
			end
			put_image($urandom_range(3, 10), $urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) == 0)
				put(8'($urandom), 1'($urandom_range(0, 1)));
		end
		wait (pending_bytes.size() == 0);
		stim_done = 1;
	end

	// Records whether the offered input beat was taken at the last rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_fire <= 1'b0;
		else
			in_fire <= s_axis_tvalid && s_axis_tready;
	end

	// Driver: offers queued bytes, changes at the falling edge.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
		end else if (!s_axis_tvalid || in_fire) begin
			if (pending_bytes.size() > 0 && !hold_sender
					&& (calm_in || $urandom_range(0, 99) >= 30)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_bytes[0].value;
				s_axis_tlast <= pending_bytes[0].fin;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= calm_out || ($urandom_range(0, 99) >= 30);
	end

	// Monitor: predicts on each accepted input beat, checks each output beat.
	always @(posedge clk) begin
		beat_t exp_b;
		beat_t got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(pending_bytes.pop_front());
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser;
				got.bytes = m_axis_tdata[63:0];
				got.count = m_axis_tdata[67:64];
				got.length = m_axis_tdata[91:68];
				got.last = m_axis_tlast;
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output beat %h", got);
				end else begin
					exp_b = expected_beats.pop_front();
					if (got !== exp_b) begin
						mismatches++;
						if (mismatches <= 10)
							$display("beat mismatch: kind %0d/%0d bytes %h/%h count %0d/%0d len %0d/%0d last %0d/%0d",
								exp_b.kind, got.kind, exp_b.bytes, got.bytes,
								exp_b.count, got.count, exp_b.length, got.length,
								exp_b.last, got.last);
					end
				end
			end
		end
	end

	// End of run and timeout.
	initial begin
		cycles = 0;
		while (!(stim_done && expected_beats.size() == 0) && cycles < MAX_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= MAX_CYCLES) begin
			$display("tb_top: errors");
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (mismatches == 0 && expected_beats.size() == 0)
				$display("tb_top: clean");
			else
				$display("tb_top: errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/blzd_pkg.sv
hdl/blzd_ram.sv
hdl/blzd_front.sv
hdl/blzd_queue.sv
hdl/blzd_back.sv
hdl/backward_lz_byte_decompressor_unit.sv
tb/sv/tb_top.sv
